// ----- rtl/ata_pio_pkg.sv -----
// ----------------------------------------------------------------------------
// ATA PIO sequencer package
// Shared item types, codes and sizes of the LBA28 task-file sequencer.
// ----------------------------------------------------------------------------
package ata_pio_pkg;

	// Sizes
	localparam int WORDS_PER_SECTOR_DEF = 256;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int IDX_W = $clog2(MAX_RESULTS);
	localparam int CFG_INDEX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_IO_BASE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL = 1'd1;
	localparam logic [15:0] IO_BASE_RESET = 16'h01F0;
	localparam logic [7:0]  CONTROL_RESET = 8'h00;

	// Actions of an input item
	localparam logic [2:0] ACT_READ     = 3'd0;
	localparam logic [2:0] ACT_WRITE    = 3'd1;
	localparam logic [2:0] ACT_RESET    = 3'd2;
	localparam logic [2:0] ACT_REPLY    = 3'd3;
	localparam logic [2:0] ACT_IRQ      = 3'd4;
	localparam logic [2:0] ACT_HOSTWORD = 3'd5;

	// Bus operations
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_BRD  = 3'd1;
	localparam logic [2:0] OP_BWR  = 3'd2;
	localparam logic [2:0] OP_WRD  = 3'd3;
	localparam logic [2:0] OP_WWR  = 3'd4;

	// Request status codes
	localparam logic [1:0] STAT_PROGRESS = 2'd0;
	localparam logic [1:0] STAT_DONE     = 2'd1;
	localparam logic [1:0] STAT_ZERO     = 2'd2;
	localparam logic [1:0] STAT_BUSY     = 2'd3;

	// Task-file register offsets
	localparam logic [15:0] REG_DATA    = 16'h0000;
	localparam logic [15:0] REG_ERROR   = 16'h0001;
	localparam logic [15:0] REG_FEATURE = 16'h0001;
	localparam logic [15:0] REG_COUNT   = 16'h0002;
	localparam logic [15:0] REG_LBA0    = 16'h0003;
	localparam logic [15:0] REG_LBA1    = 16'h0004;
	localparam logic [15:0] REG_LBA2    = 16'h0005;
	localparam logic [15:0] REG_DEVICE  = 16'h0006;
	localparam logic [15:0] REG_COMMAND = 16'h0007;
	localparam logic [15:0] REG_STATUS  = 16'h0007;
	localparam logic [15:0] REG_ALT     = 16'h0206;

	// Command and status bytes
	localparam logic [7:0] CMD_READ   = 8'h20;
	localparam logic [7:0] CMD_WRITE  = 8'h30;
	localparam logic [7:0] SEL_MASTER = 8'b1110_0000;
	localparam logic [7:0] SEL_SLAVE  = 8'b1111_0000;
	localparam logic [7:0] CTL_SRST   = 8'h04;
	localparam logic [7:0] MASK_DRDY  = 8'h40;
	localparam logic [7:0] MASK_DRQ   = 8'h08;
	localparam logic [7:0] MASK_NONE  = 8'h00;

	// Transfer direction
	localparam logic [1:0] DIR_READ  = 2'd0;
	localparam logic [1:0] DIR_WRITE = 2'd1;
	localparam logic [1:0] DIR_RESET = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_POLL,
		PH_ERRREAD,
		PH_WAITIRQ,
		PH_IRQSTAT,
		PH_RDATA,
		PH_WDATA
	} phase_t;

	typedef enum logic [1:0] {
		PS_READY,
		PS_SECTOR,
		PS_RST1,
		PS_RST2
	} poll_stage_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [27:0] lba;
		logic [7:0]  sector_count;
		logic        drive;
		logic [15:0] bus_data;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  bus_op;
		logic [15:0] bus_addr;
		logic [15:0] bus_wdata;
		logic [15:0] host_data;
		logic        host_data_valid;
		logic        host_word_request;
		logic [7:0]  error_bits;
		logic        error_valid;
		logic [1:0]  status;
		logic        last;
	} out_item_t;

	// Results caused by one input item, handed to the output stage
	typedef struct packed {
		out_item_t [MAX_RESULTS-1:0] rows;
		logic [CNT_W-1:0]            count;
	} burst_t;

endpackage

// ----- rtl/ata_pio_lba28_host_sequencer.sv -----
// ----------------------------------------------------------------------------
// ATA PIO LBA28 host sequencer
// Turns read, write and soft-reset requests, bus replies, interrupts and
// host words into task-file bus accesses and status reports.
// ----------------------------------------------------------------------------
// An item is taken into an input register; once the output stage is free,
// its whole effect on the transfer state is applied in one step while the
// list of results it causes (zero to eight) moves into the output stage.
// The output stage delivers one result per cycle while the result port is
// not stalled. Input items are accepted one per cycle as long as each
// causes at most one result and the result port is not stalled; an item
// with n results holds the output until all n are taken, and the input
// stalls only while the input register waits for the output stage to
// drain. Configuration writes are taken in any cycle and should be made
// with no request in progress.
module ata_pio_lba28_host_sequencer
	import ata_pio_pkg::*;
#(
	parameter int WORDS_PER_SECTOR = WORDS_PER_SECTOR_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  in_item_t               item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output out_item_t              result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]            cfg_data
);

	logic        valid_s1;
	in_item_t    item_s1;
	logic [15:0] io_base_q;
	logic [7:0]  control_value_q;
	logic        free;
	logic        step;
	logic        accept;
	burst_t      burst;

	assign step       = valid_s1 && free;
	assign item_stall = valid_s1 && !free;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			io_base_q       <= IO_BASE_RESET;
			control_value_q <= CONTROL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_IO_BASE: io_base_q       <= cfg_data;
				CFG_CONTROL: control_value_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (step)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
	end

	ata_pio_core #(
		.WORDS_PER_SECTOR(WORDS_PER_SECTOR)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.item         (item_s1),
		.io_base      (io_base_q),
		.control_value(control_value_q),
		.burst        (burst)
	);

	ata_pio_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (valid_s1),
		.burst       (burst),
		.free        (free),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

// ----- rtl/ata_pio_core.sv -----
// ----------------------------------------------------------------------------
// ATA PIO sequencer core
// Holds the transfer state and turns one registered input item into the
// list of bus accesses and reports that it causes.
// ----------------------------------------------------------------------------
module ata_pio_core
	import ata_pio_pkg::*;
#(
	parameter int WORDS_PER_SECTOR = WORDS_PER_SECTOR_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  in_item_t   item,
	input  logic [15:0] io_base,
	input  logic [7:0] control_value,
	output burst_t     burst
);

	localparam int WI_W = $clog2(WORDS_PER_SECTOR);
	localparam int EVAL_MAX = MAX_RESULTS - 1;

	// Transfer state
	phase_t           phase_q, phase_d;
	poll_stage_t      stage_q, stage_d;
	logic [7:0]       wait_mask_q, wait_mask_d;
	logic [7:0]       held_q, held_d;
	logic [7:0]       sectors_q, sectors_d;
	logic [WI_W-1:0]  word_q, word_d;
	logic [27:0]      addr_q, addr_d;
	logic             drive_q, drive_d;
	logic [1:0]       dir_q, dir_d;

	// Shared decode
	logic             idle;
	logic             zero_cnt;
	logic [7:0]       stat_s;
	logic             poll_fail;
	logic             do_eval;
	logic             poll_pass;
	logic             word_end;
	logic             sec_end;
	logic [7:0]       sel_in;
	logic [7:0]       sel_q;

	out_item_t [EVAL_MAX-1:0]    eval_rows;
	logic [CNT_W-1:0]            eval_n;
	out_item_t [MAX_RESULTS-1:0] rows;
	logic [CNT_W-1:0]            n;

	function automatic out_item_t mk_row(input logic [2:0] op, input logic [15:0] off,
			input logic [15:0] wdata, input logic [15:0] base);
		out_item_t r;
		r = '0;
		r.bus_op = op;
		r.bus_addr = (op == OP_NONE) ? 16'h0000 : base + off;
		r.bus_wdata = wdata;
		return r;
	endfunction

	assign idle      = (phase_q == PH_IDLE);
	assign zero_cnt  = (item.sector_count == 8'h00);
	assign stat_s    = (phase_q == PH_ERRREAD) ? held_q : item.bus_data[7:0];
	assign poll_fail = stat_s[7] || ((stat_s & wait_mask_q) != wait_mask_q);
	assign do_eval   = (item.action == ACT_REPLY) &&
		(((phase_q == PH_POLL) && !item.bus_data[0]) || (phase_q == PH_ERRREAD));
	assign poll_pass = do_eval && !poll_fail;
	assign word_end  = (({1'b0, word_q} + 1'b1) == (WI_W + 1)'(WORDS_PER_SECTOR));
	assign sec_end   = (sectors_q == 8'h01);
	assign sel_in    = item.drive ? SEL_SLAVE : SEL_MASTER;
	assign sel_q     = drive_q ? SEL_SLAVE : SEL_MASTER;

	// Next transfer state
	always_comb begin
		phase_d     = phase_q;
		stage_d     = stage_q;
		wait_mask_d = wait_mask_q;
		held_d      = held_q;
		sectors_d   = sectors_q;
		word_d      = word_q;
		addr_d      = addr_q;
		drive_d     = drive_q;
		dir_d       = dir_q;
		unique case (item.action) inside
			ACT_READ, ACT_WRITE: begin
				if (!zero_cnt && idle) begin
					dir_d       = item.action[1:0];
					addr_d      = item.lba;
					sectors_d   = item.sector_count;
					drive_d     = item.drive;
					word_d      = '0;
					stage_d     = PS_READY;
					wait_mask_d = MASK_DRDY;
					phase_d     = PH_POLL;
				end
			end
			ACT_RESET: begin
				if (idle) begin
					dir_d       = DIR_RESET;
					stage_d     = PS_RST1;
					wait_mask_d = MASK_NONE;
					phase_d     = PH_POLL;
				end
			end
			ACT_REPLY: begin
				unique case (phase_q)
					PH_POLL: begin
						if (item.bus_data[0]) begin
							held_d  = item.bus_data[7:0];
							phase_d = PH_ERRREAD;
						end
					end
					PH_ERRREAD: begin
						phase_d = PH_POLL;
					end
					PH_IRQSTAT: begin
						stage_d     = PS_SECTOR;
						wait_mask_d = (dir_q == DIR_READ) ? MASK_DRQ : MASK_NONE;
						phase_d     = PH_POLL;
					end
					PH_RDATA: begin
						if (word_end) begin
							word_d    = '0;
							sectors_d = sectors_q - 8'h01;
							phase_d   = sec_end ? PH_IDLE : PH_WAITIRQ;
						end else begin
							word_d = word_q + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			ACT_IRQ: begin
				if (phase_q == PH_WAITIRQ)
					phase_d = PH_IRQSTAT;
			end
			ACT_HOSTWORD: begin
				if (phase_q == PH_WDATA) begin
					if (word_end) begin
						word_d  = '0;
						phase_d = PH_WAITIRQ;
					end else begin
						word_d = word_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		// A finished poll continues with whatever its stage calls for
		if (poll_pass) begin
			unique case (stage_q)
				PS_READY: begin
					word_d  = '0;
					phase_d = (dir_q == DIR_WRITE) ? PH_WDATA : PH_WAITIRQ;
				end
				PS_SECTOR: begin
					word_d = '0;
					if (dir_q == DIR_READ) begin
						phase_d = PH_RDATA;
					end else begin
						sectors_d = sectors_q - 8'h01;
						phase_d   = sec_end ? PH_IDLE : PH_WDATA;
					end
				end
				PS_RST1: begin
					stage_d     = PS_RST2;
					wait_mask_d = MASK_NONE;
					phase_d     = PH_POLL;
				end
				PS_RST2: begin
					phase_d = PH_IDLE;
				end
				default: begin
				end
			endcase
		end
	end

	// Results of a status evaluation: repoll, continue or finish the request
	always_comb begin
		eval_rows = '0;
		eval_n    = '0;
		if (poll_fail) begin
			eval_rows[0] = mk_row(OP_BRD, REG_ALT, 16'h0000, io_base);
			eval_n       = CNT_W'(1);
		end else begin
			unique case (stage_q)
				PS_READY: begin
					eval_rows[0] = mk_row(OP_BWR, REG_FEATURE, 16'h0000, io_base);
					eval_rows[1] = mk_row(OP_BWR, REG_COUNT, {8'h00, sectors_q}, io_base);
					eval_rows[2] = mk_row(OP_BWR, REG_LBA0, {8'h00, addr_q[7:0]}, io_base);
					eval_rows[3] = mk_row(OP_BWR, REG_LBA1, {8'h00, addr_q[15:8]}, io_base);
					eval_rows[4] = mk_row(OP_BWR, REG_LBA2, {8'h00, addr_q[23:16]}, io_base);
					eval_rows[5] = mk_row(OP_BWR, REG_DEVICE,
						{8'h00, sel_q | {4'h0, addr_q[27:24]}}, io_base);
					eval_rows[6] = mk_row(OP_BWR, REG_COMMAND,
						{8'h00, (dir_q == DIR_WRITE) ? CMD_WRITE : CMD_READ}, io_base);
					eval_rows[6].host_word_request = (dir_q == DIR_WRITE);
					eval_n = CNT_W'(7);
				end
				PS_SECTOR: begin
					if (dir_q == DIR_READ) begin
						eval_rows[0] = mk_row(OP_WRD, REG_DATA, 16'h0000, io_base);
					end else begin
						eval_rows[0] = mk_row(OP_NONE, REG_DATA, 16'h0000, io_base);
						if (sec_end)
							eval_rows[0].status = STAT_DONE;
						else
							eval_rows[0].host_word_request = 1'b1;
					end
					eval_n = CNT_W'(1);
				end
				PS_RST1: begin
					eval_rows[0] = mk_row(OP_BWR, REG_ALT, {8'h00, control_value}, io_base);
					eval_rows[1] = mk_row(OP_BRD, REG_ALT, 16'h0000, io_base);
					eval_n       = CNT_W'(2);
				end
				PS_RST2: begin
					eval_rows[0]        = mk_row(OP_NONE, REG_DATA, 16'h0000, io_base);
					eval_rows[0].status = STAT_DONE;
					eval_n              = CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Result list of the item
	always_comb begin
		rows = '0;
		n    = '0;
		unique case (item.action) inside
			ACT_READ, ACT_WRITE: begin
				if (zero_cnt || !idle) begin
					rows[0]        = mk_row(OP_NONE, REG_DATA, 16'h0000, io_base);
					rows[0].status = zero_cnt ? STAT_ZERO : STAT_BUSY;
					n              = CNT_W'(1);
				end else begin
					rows[0] = mk_row(OP_BWR, REG_DEVICE, {8'h00, sel_in}, io_base);
					rows[1] = mk_row(OP_BRD, REG_ALT, 16'h0000, io_base);
					n       = CNT_W'(2);
				end
			end
			ACT_RESET: begin
				if (!idle) begin
					rows[0]        = mk_row(OP_NONE, REG_DATA, 16'h0000, io_base);
					rows[0].status = STAT_BUSY;
					n              = CNT_W'(1);
				end else begin
					rows[0] = mk_row(OP_BWR, REG_ALT, {8'h00, CTL_SRST}, io_base);
					rows[1] = mk_row(OP_BRD, REG_ALT, 16'h0000, io_base);
					n       = CNT_W'(2);
				end
			end
			ACT_REPLY: begin
				unique case (phase_q)
					PH_POLL: begin
						if (item.bus_data[0]) begin
							rows[0] = mk_row(OP_BRD, REG_ERROR, 16'h0000, io_base);
							n       = CNT_W'(1);
						end else begin
							rows[EVAL_MAX-1:0] = eval_rows;
							n                  = eval_n;
						end
					end
					PH_ERRREAD: begin
						// Error report goes ahead of the accesses the held status causes
						rows[0]             = mk_row(OP_NONE, REG_DATA, 16'h0000, io_base);
						rows[0].error_bits  = item.bus_data[7:0];
						rows[0].error_valid = 1'b1;
						rows[MAX_RESULTS-1:1] = eval_rows;
						n = eval_n + 1'b1;
					end
					PH_IRQSTAT: begin
						rows[0] = mk_row(OP_BRD, REG_ALT, 16'h0000, io_base);
						n       = CNT_W'(1);
					end
					PH_RDATA: begin
						rows[0] = mk_row(OP_NONE, REG_DATA, 16'h0000, io_base);
						rows[0].host_data       = item.bus_data;
						rows[0].host_data_valid = 1'b1;
						if (word_end) begin
							if (sec_end)
								rows[0].status = STAT_DONE;
							n = CNT_W'(1);
						end else begin
							rows[1] = mk_row(OP_WRD, REG_DATA, 16'h0000, io_base);
							n       = CNT_W'(2);
						end
					end
					default: begin
					end
				endcase
			end
			ACT_IRQ: begin
				if (phase_q == PH_WAITIRQ) begin
					rows[0] = mk_row(OP_BRD, REG_STATUS, 16'h0000, io_base);
					n       = CNT_W'(1);
				end
			end
			ACT_HOSTWORD: begin
				if (phase_q == PH_WDATA) begin
					rows[0] = mk_row(OP_WWR, REG_DATA, item.bus_data, io_base);
					rows[0].host_word_request = !word_end;
					n = CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign burst.rows  = rows;
	assign burst.count = n;

	// Advance the state when the item retires into the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			stage_q     <= PS_READY;
			wait_mask_q <= '0;
			held_q      <= '0;
			sectors_q   <= '0;
			word_q      <= '0;
			addr_q      <= '0;
			drive_q     <= 1'b0;
			dir_q       <= DIR_READ;
		end else if (step) begin
			phase_q     <= phase_d;
			stage_q     <= stage_d;
			wait_mask_q <= wait_mask_d;
			held_q      <= held_d;
			sectors_q   <= sectors_d;
			word_q      <= word_d;
			addr_q      <= addr_d;
			drive_q     <= drive_d;
			dir_q       <= dir_d;
		end
	end

endmodule

// ----- rtl/ata_pio_emit.sv -----
// ----------------------------------------------------------------------------
// ATA PIO sequencer result stage
// Holds the result list of one item and hands it out one result per cycle while the result port is not stalled.
// ----------------------------------------------------------------------------
module ata_pio_emit
	import ata_pio_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  burst_t    burst,
	output logic      free,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	out_item_t [MAX_RESULTS-1:0] rows_q;
	logic [IDX_W-1:0]            idx_q;
	logic [IDX_W-1:0]            last_idx_q;
	logic                        busy_q;
	logic                        take;
	logic                        at_last;
	out_item_t                   cur;

	assign take    = busy_q && !result_stall;
	assign at_last = (idx_q == last_idx_q);
	assign free    = !busy_q || (take && at_last);

	// Drive the current result, marking the final one of the list
	always_comb begin
		cur      = rows_q[idx_q];
		cur.last = at_last;
	end

	assign result_valid = busy_q;
	assign result       = cur;

	// Hold the list payload
	always_ff @(posedge clk) begin
		if (load && free)
			rows_q <= burst.rows;
	end

	// Advance through the list, load the next when the last is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= '0;
			last_idx_q <= '0;
		end else if (free) begin
			busy_q     <= load && (burst.count != '0);
			idx_q      <= '0;
			last_idx_q <= IDX_W'(burst.count - 1'b1);
		end else if (take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

// ----- rtl/ata_pio_checker.sv -----
// ----------------------------------------------------------------------------
// ATA PIO sequencer checker
// Port-level properties of the sequencer's result stream.
// ----------------------------------------------------------------------------
module ata_pio_checker
	import ata_pio_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	// Hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// Drop the address on a result with no bus access
	a_none_addr: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.bus_op == OP_NONE) |-> (result.bus_addr == 16'h0000))
		else $error("address on a result without bus access");

	// Sector data comes in a report of its own
	a_data_report: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.host_data_valid |-> (result.bus_op == OP_NONE))
		else $error("sector word on a bus access");

	// An error report is always followed by the repoll or the next accesses
	a_error_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error_valid |-> !result.last)
		else $error("error report ends a result list");

	// A final status closes the result list of its item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != STAT_PROGRESS) |-> result.last)
		else $error("final status not on the last result");

endmodule

bind ata_pio_lba28_host_sequencer ata_pio_checker u_checker (.*);
